@@ src/maac_pkg.sv @@
`timescale 1ns / 1ps
package maac_pkg;

	// input word and result word
	typedef struct packed {
		logic        cmd;
		logic [20:0] code_in;
	} in_word_t;

	typedef struct packed {
		logic [20:0] code_out;
		logic [2:0]  char_class;
		logic        no_inverse;
	} out_word_t;

	// commands
	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	// register indexes on the configuration port
	localparam logic REG_KEY_MULT  = 1'b0;
	localparam logic REG_KEY_SHIFT = 1'b1;

	// character classes
	localparam logic [2:0] CLS_PASS    = 3'd0;
	localparam logic [2:0] CLS_CYR_UP  = 3'd1;
	localparam logic [2:0] CLS_CYR_LO  = 3'd2;
	localparam logic [2:0] CLS_LAT_UP  = 3'd3;
	localparam logic [2:0] CLS_LAT_LO  = 3'd4;
	localparam logic [2:0] CLS_DIGIT   = 3'd5;
	localparam logic [2:0] CLS_SYMBOL  = 3'd6;

	// alphabet sizes, one slot per distinct modulus
	typedef enum logic [1:0] {
		MOD32 = 2'd0,
		MOD26 = 2'd1,
		MOD10 = 2'd2,
		MOD33 = 2'd3
	} mod_id_t;

	localparam logic [5:0] M32 = 6'd32;
	localparam logic [5:0] M26 = 6'd26;
	localparam logic [5:0] M10 = 6'd10;
	localparam logic [5:0] M33 = 6'd33;

	// reduced keys and inverses for every modulus
	typedef struct packed {
		logic [3:0][5:0] a;
		logic [3:0][5:0] b;
		logic [3:0][5:0] inv;
	} key_set_t;

	// reciprocals for the exact quotient of a 16-bit value
	localparam int RECIP_SH = 22;
	localparam logic [19:0] R26 = 20'(((2 ** 22) + 25) / 26);
	localparam logic [19:0] R10 = 20'(((2 ** 22) + 9) / 10);
	localparam logic [19:0] R33 = 20'(((2 ** 22) + 32) / 33);

	function automatic logic [5:0] modulus(input mod_id_t id);
		logic [5:0] m;
		case (id)
			MOD32:   m = M32;
			MOD26:   m = M26;
			MOD10:   m = M10;
			MOD33:   m = M33;
			default: m = M32;
		endcase
		return m;
	endfunction

	// v mod m by reciprocal multiply, quotient is exact over 16 bits
	function automatic logic [5:0] mod_by(input logic [15:0] v, input mod_id_t id);
		logic [39:0] p;
		logic [15:0] q;
		logic [15:0] r;
		p = '0;
		case (id)
			MOD26:   p = 40'(v) * 40'(R26);
			MOD10:   p = 40'(v) * 40'(R10);
			MOD33:   p = 40'(v) * 40'(R33);
			default: p = '0;
		endcase
		q = p[RECIP_SH +: 16];
		case (id)
			MOD32:   r = {11'b0, v[4:0]};
			MOD26:   r = v - 16'(q * {10'b0, M26});
			MOD10:   r = v - 16'(q * {10'b0, M10});
			MOD33:   r = v - 16'(q * {10'b0, M33});
			default: r = '0;
		endcase
		return r[5:0];
	endfunction

	// inverse tables, zero where none exists; built at elaboration
	typedef logic [32:0][5:0] inv_tab_t;

	function automatic inv_tab_t build_inv(input int m);
		inv_tab_t t;
		int       p;
		int       a;
		int       x;
		t = '0;
		for (a = 0; a < 33; a++) begin
			p = 0;
			if (a < m) begin
				for (x = 1; x < m; x++) begin
					p = p + a;
					if (p >= m) p = p - m;
					if (p == 1 && t[a] == 6'd0) t[a] = 6'(x);
				end
			end
		end
		return t;
	endfunction

	localparam inv_tab_t INV32 = build_inv(32);
	localparam inv_tab_t INV26 = build_inv(26);
	localparam inv_tab_t INV10 = build_inv(10);
	localparam inv_tab_t INV33 = build_inv(33);

endpackage

@@ src/maac_keys.sv @@
`timescale 1ns / 1ps
module maac_keys (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [15:0]        cfg_wdata,
	output maac_pkg::key_set_t keys
);

	logic [3:0][5:0] a_q;
	logic [3:0][5:0] b_q;
	logic [3:0][5:0] red;

	// keys are stored already reduced per modulus
	always_comb begin
		red[maac_pkg::MOD32] = maac_pkg::mod_by(cfg_wdata, maac_pkg::MOD32);
		red[maac_pkg::MOD26] = maac_pkg::mod_by(cfg_wdata, maac_pkg::MOD26);
		red[maac_pkg::MOD10] = maac_pkg::mod_by(cfg_wdata, maac_pkg::MOD10);
		red[maac_pkg::MOD33] = maac_pkg::mod_by(cfg_wdata, maac_pkg::MOD33);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= {4{6'd1}};
			b_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				maac_pkg::REG_KEY_MULT:  a_q <= red;
				maac_pkg::REG_KEY_SHIFT: b_q <= red;
				default: ;
			endcase
		end
	end

	always_comb begin
		keys.a   = a_q;
		keys.b   = b_q;
		keys.inv[maac_pkg::MOD32] = maac_pkg::INV32[a_q[maac_pkg::MOD32]];
		keys.inv[maac_pkg::MOD26] = maac_pkg::INV26[a_q[maac_pkg::MOD26]];
		keys.inv[maac_pkg::MOD10] = maac_pkg::INV10[a_q[maac_pkg::MOD10]];
		keys.inv[maac_pkg::MOD33] = maac_pkg::INV33[a_q[maac_pkg::MOD33]];
	end

endmodule

@@ src/maac_xform.sv @@
`timescale 1ns / 1ps
module maac_xform (
	input  maac_pkg::in_word_t  item,
	input  maac_pkg::key_set_t  keys,
	output maac_pkg::out_word_t result
);

	localparam logic [20:0] CYR_UP_LO = 21'h410;
	localparam logic [20:0] CYR_UP_HI = 21'h42F;
	localparam logic [20:0] CYR_LO_LO = 21'h430;
	localparam logic [20:0] CYR_LO_HI = 21'h44F;
	localparam logic [20:0] LAT_UP_LO = 21'h41;
	localparam logic [20:0] LAT_UP_HI = 21'h5A;
	localparam logic [20:0] LAT_LO_LO = 21'h61;
	localparam logic [20:0] LAT_LO_HI = 21'h7A;
	localparam logic [20:0] DIG_LO    = 21'h30;
	localparam logic [20:0] DIG_HI    = 21'h39;

	function automatic logic [6:0] sym_char(input logic [5:0] y);
		logic [6:0] c;
		if (y <= 6'd14)      c = 7'h21 + 7'(y);
		else if (y <= 6'd21) c = 7'h2B + 7'(y);
		else if (y <= 6'd27) c = 7'h45 + 7'(y);
		else                 c = 7'h5F + 7'(y);
		return c;
	endfunction

	logic [20:0]       c;
	logic [2:0]        cls;
	logic [20:0]       base;
	logic [5:0]        x;
	maac_pkg::mod_id_t id;
	logic [5:0]        m;
	logic [5:0]        a;
	logic [5:0]        b;
	logic [5:0]        inv;
	logic [5:0]        d;
	logic [10:0]       t;
	logic [5:0]        y;
	logic              no_inv;

	assign c = item.code_in;

	// classify and take the letter index
	always_comb begin
		cls  = maac_pkg::CLS_PASS;
		base = '0;
		x    = '0;
		id   = maac_pkg::MOD32;
		if (c >= CYR_UP_LO && c <= CYR_UP_HI) begin
			cls = maac_pkg::CLS_CYR_UP; base = CYR_UP_LO; id = maac_pkg::MOD32;
		end else if (c >= CYR_LO_LO && c <= CYR_LO_HI) begin
			cls = maac_pkg::CLS_CYR_LO; base = CYR_LO_LO; id = maac_pkg::MOD32;
		end else if (c >= LAT_UP_LO && c <= LAT_UP_HI) begin
			cls = maac_pkg::CLS_LAT_UP; base = LAT_UP_LO; id = maac_pkg::MOD26;
		end else if (c >= LAT_LO_LO && c <= LAT_LO_HI) begin
			cls = maac_pkg::CLS_LAT_LO; base = LAT_LO_LO; id = maac_pkg::MOD26;
		end else if (c >= DIG_LO && c <= DIG_HI) begin
			cls = maac_pkg::CLS_DIGIT; base = DIG_LO; id = maac_pkg::MOD10;
		end else if (c >= 21'h21 && c <= 21'h2F) begin
			cls = maac_pkg::CLS_SYMBOL; id = maac_pkg::MOD33; base = 21'h21;
		end else if (c >= 21'h3A && c <= 21'h40) begin
			cls = maac_pkg::CLS_SYMBOL; id = maac_pkg::MOD33; base = 21'h2B;
		end else if (c >= 21'h5B && c <= 21'h60) begin
			cls = maac_pkg::CLS_SYMBOL; id = maac_pkg::MOD33; base = 21'h45;
		end else if (c >= 21'h7B && c <= 21'h7F) begin
			cls = maac_pkg::CLS_SYMBOL; id = maac_pkg::MOD33; base = 21'h5F;
		end
		x = 6'(c - base);
	end

	// affine map on the index
	always_comb begin
		m   = maac_pkg::modulus(id);
		a   = keys.a[id];
		b   = keys.b[id];
		inv = keys.inv[id];
		d   = (x >= b) ? 6'(x - b) : 6'(x + m - b);
		if (item.cmd == maac_pkg::CMD_ENCRYPT) begin
			t = 11'({5'b0, a} * {5'b0, x}) + {5'b0, b};
		end else begin
			t = 11'({5'b0, inv} * {5'b0, d});
		end
		y      = maac_pkg::mod_by({5'b0, t}, id);
		no_inv = (cls != maac_pkg::CLS_PASS) && (item.cmd == maac_pkg::CMD_DECRYPT)
			&& (inv == 6'd0);
	end

	always_comb begin
		result.char_class = cls;
		result.no_inverse = no_inv;
		if (cls == maac_pkg::CLS_PASS || no_inv) begin
			result.code_out = c;
		end else if (cls == maac_pkg::CLS_SYMBOL) begin
			result.code_out = {14'b0, sym_char(y)};
		end else begin
			result.code_out = base + {15'b0, y};
		end
	end

endmodule

@@ src/multi_alphabet_affine_cipher.sv @@
`timescale 1ns / 1ps
// channel   valid         stall          word
// input     item_valid    item_stall     item   (cmd, code_in)
// result    result_valid  result_stall   result (code_out, char_class, no_inverse)
// config    cfg_we        -              cfg_idx, cfg_wdata
//
// two register stages: a word is taken into the input register, transformed by
// combinational logic and lands in the result register, from which it is offered,
// one word per cycle while result_stall is low
// the rate is set by the single pass through the classify / multiply / reduce logic
// reset loads key_mult = 1 and key_shift = 0 (identity map)
// result_stall holds the result register; the input register still fills behind it,
// so item_stall rises only when both stages hold a word and the result is stalled
module multi_alphabet_affine_cipher (
	input  logic                clk,
	input  logic                arst_n,
	// input words
	input  logic                item_valid,
	output logic                item_stall,
	input  maac_pkg::in_word_t  item,
	// result words
	output logic                result_valid,
	input  logic                result_stall,
	output maac_pkg::out_word_t result,
	// configuration writes
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [15:0]         cfg_wdata
);

	maac_pkg::key_set_t  keys;
	maac_pkg::in_word_t  item_s1;
	logic                valid_s1;
	maac_pkg::out_word_t xform_out;
	maac_pkg::out_word_t result_s2;
	logic                valid_s2;
	logic                adv_s1;
	logic                adv_s2;

	// key registers, kept reduced per alphabet size
	maac_keys u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.keys      (keys)
	);

	// a stage moves when it is empty or the stage after it is draining
	assign adv_s2     = !valid_s2 || !result_stall;
	assign adv_s1     = !valid_s1 || adv_s2;
	assign item_stall = !adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_valid) begin
			item_s1 <= item;
		end
	end

	// per-character transform
	maac_xform u_xform (
		.item   (item_s1),
		.keys   (keys),
		.result (xform_out)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= xform_out;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule
